// ===== design/msi_pkg.sv =====
package msi_pkg;

  typedef enum logic [2:0] {
    OP_PUMP       = 3'd0,
    OP_CHAIN      = 3'd1,
    OP_SERVO_OK   = 3'd2,
    OP_GAUGE_LINK = 3'd3,
    OP_SERVO_LINK = 3'd4,
    OP_STATUS     = 3'd5,
    OP_CONDITION  = 3'd6,
    OP_MODE       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    RES_WRITTEN   = 2'd0,
    RES_REFUSED   = 2'd1,
    RES_OUT_RANGE = 2'd2
  } res_t;

  typedef enum logic [1:0] {
    PH_SELF_CHECK    = 2'd0,
    PH_MACHINE_CHECK = 2'd1,
    PH_MOTION        = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_DISABLED      = 3'd0,
    ST_ENABLED       = 3'd1,
    ST_FAULTED       = 3'd2,
    ST_SAMPLE_LIMIT  = 3'd3,
    ST_MACHINE_LIMIT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MD_MANUAL   = 2'd0,
    MD_TEST     = 2'd1,
    MD_TEST_RUN = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    COND_LENGTH      = 4'd0,
    COND_FORCE       = 4'd1,
    COND_TENSION     = 4'd2,
    COND_COMPRESSION = 4'd3,
    COND_UPPER       = 4'd4,
    COND_LOWER       = 4'd5,
    COND_DOOR        = 4'd6,
    COND_STOPPED     = 4'd7,
    COND_MOVING      = 4'd8
  } cond_t;

  localparam logic [2:0] CHAIN_OK = 3'd0;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0] result_code;
    logic [1:0] machine_phase;
    logic [2:0] motion_status_out;
    logic [1:0] motion_mode_out;
  } result_t;

  // largest legal value for each field
  function automatic logic [3:0] field_max(input logic [2:0] op);
    logic [3:0] m;
    case (op)
      OP_PUMP, OP_SERVO_OK, OP_GAUGE_LINK, OP_SERVO_LINK: m = 4'd1;
      OP_CHAIN, OP_STATUS:                                m = 4'd4;
      OP_CONDITION:                                       m = 4'd8;
      OP_MODE:                                            m = 4'd2;
      default:                                            m = 4'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/msi_core.sv =====
module msi_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  msi_pkg::item_t    beat,
  output msi_pkg::result_t  res
);

  logic [1:0] phase_reg;
  logic       pump_ok;
  logic [2:0] stop_chain_code;
  logic       servo_ready;
  logic       gauge_link_ok;
  logic       servo_link_ok;
  logic [2:0] status_reg;
  logic [3:0] condition_reg;
  logic [1:0] mode_reg;

  logic       pump_w, servo_w, gauge_w, slink_w;
  logic [2:0] chain_w;
  logic [2:0] status_w;
  logic [3:0] cond_w;
  logic [1:0] mode_w;
  logic [1:0] code;
  logic [1:0] phase_next;
  logic [2:0] status_next;
  logic [1:0] mode_next;

  // field write
  always_comb begin
    pump_w   = pump_ok;
    chain_w  = stop_chain_code;
    servo_w  = servo_ready;
    gauge_w  = gauge_link_ok;
    slink_w  = servo_link_ok;
    status_w = status_reg;
    cond_w   = condition_reg;
    mode_w   = mode_reg;
    code     = msi_pkg::RES_WRITTEN;
    if (beat.value > msi_pkg::field_max(beat.operation)) begin
      code = msi_pkg::RES_OUT_RANGE;
    end else begin
      case (beat.operation)
        msi_pkg::OP_PUMP:       pump_w   = beat.value[0];
        msi_pkg::OP_CHAIN:      chain_w  = beat.value[2:0];
        msi_pkg::OP_SERVO_OK:   servo_w  = beat.value[0];
        msi_pkg::OP_GAUGE_LINK: gauge_w  = beat.value[0];
        msi_pkg::OP_SERVO_LINK: slink_w  = beat.value[0];
        msi_pkg::OP_STATUS:     status_w = beat.value[2:0];
        msi_pkg::OP_CONDITION:  cond_w   = beat.value;
        msi_pkg::OP_MODE: begin
          if (beat.value[1:0] == msi_pkg::MD_TEST_RUN &&
              mode_reg != msi_pkg::MD_TEST) begin
            code = msi_pkg::RES_REFUSED;
          end else begin
            mode_w = beat.value[1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // re-evaluation on the freshly written fields
  always_comb begin
    if (!pump_w) begin
      phase_next = msi_pkg::PH_SELF_CHECK;
    end else if (chain_w == msi_pkg::CHAIN_OK && servo_w && gauge_w && slink_w) begin
      phase_next = msi_pkg::PH_MOTION;
    end else begin
      phase_next = msi_pkg::PH_MACHINE_CHECK;
    end

    status_next = status_w;
    mode_next   = mode_w;
    if (phase_next != msi_pkg::PH_MOTION) begin
      // leaving or outside motion: latch a chain fault only on the way out
      if (phase_reg == msi_pkg::PH_MOTION && chain_w != msi_pkg::CHAIN_OK) begin
        status_next = msi_pkg::ST_FAULTED;
      end else begin
        status_next = msi_pkg::ST_DISABLED;
      end
      mode_next = msi_pkg::MD_MANUAL;
    end else if (status_w != msi_pkg::ST_DISABLED) begin
      case (cond_w)
        msi_pkg::COND_LENGTH, msi_pkg::COND_FORCE:
          status_next = msi_pkg::ST_SAMPLE_LIMIT;
        msi_pkg::COND_TENSION, msi_pkg::COND_COMPRESSION, msi_pkg::COND_UPPER,
        msi_pkg::COND_LOWER, msi_pkg::COND_DOOR:
          status_next = msi_pkg::ST_MACHINE_LIMIT;
        msi_pkg::COND_STOPPED, msi_pkg::COND_MOVING:
          status_next = msi_pkg::ST_ENABLED;
        default: ;
      endcase
    end else begin
      mode_next = msi_pkg::MD_MANUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg       <= msi_pkg::PH_SELF_CHECK;
      pump_ok         <= 1'b0;
      stop_chain_code <= msi_pkg::CHAIN_OK;
      servo_ready     <= 1'b0;
      gauge_link_ok   <= 1'b0;
      servo_link_ok   <= 1'b0;
      status_reg      <= msi_pkg::ST_DISABLED;
      condition_reg   <= msi_pkg::COND_STOPPED;
      mode_reg        <= msi_pkg::MD_MANUAL;
    end else if (fire) begin
      phase_reg       <= phase_next;
      pump_ok         <= pump_w;
      stop_chain_code <= chain_w;
      servo_ready     <= servo_w;
      gauge_link_ok   <= gauge_w;
      servo_link_ok   <= slink_w;
      status_reg      <= status_next;
      condition_reg   <= cond_w;
      mode_reg        <= mode_next;
    end
  end

  assign res.result_code       = code;
  assign res.machine_phase     = phase_next;
  assign res.motion_status_out = status_next;
  assign res.motion_mode_out   = mode_next;

endmodule

// ===== design/motion_safety_interlock.sv =====
// Safety interlock for a test machine drive. Each item writes one status field
// (pump, stop chain, servo ok, gauge link, servo link, motion status, condition
// or mode) and returns the re-evaluated phase, motion status and mode with a
// result code. One item per cycle is sustained while the result side does not stall; the
// accepted item sits in the input register while the field update and
// phase/status decision run, and lands in the result register once the result
// register can advance. Stall on the result side backs up through the
// input register to item_stall.
module motion_safety_interlock (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  msi_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output msi_pkg::result_t  result
);

  logic             held_valid;
  msi_pkg::item_t   held;
  logic             advance;
  logic             fire;
  msi_pkg::result_t core_res;

  assign advance    = !result_valid || !result_stall;
  assign fire       = held_valid && advance;
  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      held <= item;
    end
  end

  msi_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .beat (held),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_res;
    end
  end

endmodule

// ===== design/msi_checker.sv =====
module msi_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input msi_pkg::result_t result
);

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // outside motion the mode is manual and status is disabled or faulted
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.machine_phase != msi_pkg::PH_MOTION |->
      result.motion_mode_out == msi_pkg::MD_MANUAL &&
      (result.motion_status_out == msi_pkg::ST_DISABLED ||
       result.motion_status_out == msi_pkg::ST_FAULTED))
    else $error("mode or status not forced outside motion");

  // in motion with disabled status the mode is forced to manual
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.machine_phase == msi_pkg::PH_MOTION &&
      result.motion_status_out == msi_pkg::ST_DISABLED |->
      result.motion_mode_out == msi_pkg::MD_MANUAL)
    else $error("mode not manual while disabled in motion");

endmodule

bind motion_safety_interlock msi_checker u_msi_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== sim/msi_checker.sv =====
module msi_scoreboard (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  msi_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  msi_pkg::result_t result,
  output int               fail_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the interlock state
  msi_pkg::phase_t  phase_now;
  logic             pump_on;
  logic [2:0]       chain_code;
  logic             servo_on;
  logic             gauge_on;
  logic             link_on;
  msi_pkg::status_t status_now;
  msi_pkg::cond_t   cond_now;
  msi_pkg::mode_t   mode_now;

  msi_pkg::result_t interlock_reports[$];

  // apply one field write, then re-evaluate phase, status and mode
  function automatic msi_pkg::result_t apply_write(msi_pkg::item_t it);
    logic [3:0]       top;
    msi_pkg::res_t    code;
    msi_pkg::phase_t  next_ph;
    msi_pkg::result_t r;
    code = msi_pkg::RES_WRITTEN;
    case (msi_pkg::op_t'(it.operation))
      msi_pkg::OP_CHAIN, msi_pkg::OP_STATUS: top = 4'd4;
      msi_pkg::OP_CONDITION:                 top = 4'd8;
      msi_pkg::OP_MODE:                      top = 4'd2;
      default:                               top = 4'd1;
    endcase
    if (it.value > top) begin
      code = msi_pkg::RES_OUT_RANGE;
    end else begin
      case (msi_pkg::op_t'(it.operation))
        msi_pkg::OP_PUMP:       pump_on    = it.value[0];
        msi_pkg::OP_CHAIN:      chain_code = it.value[2:0];
        msi_pkg::OP_SERVO_OK:   servo_on   = it.value[0];
        msi_pkg::OP_GAUGE_LINK: gauge_on   = it.value[0];
        msi_pkg::OP_SERVO_LINK: link_on    = it.value[0];
        msi_pkg::OP_STATUS:     status_now = msi_pkg::status_t'(it.value[2:0]);
        msi_pkg::OP_CONDITION:  cond_now   = msi_pkg::cond_t'(it.value);
        default: begin
          // test running only from test mode
          if (msi_pkg::mode_t'(it.value[1:0]) == msi_pkg::MD_TEST_RUN &&
              mode_now != msi_pkg::MD_TEST)
            code = msi_pkg::RES_REFUSED;
          else
            mode_now = msi_pkg::mode_t'(it.value[1:0]);
        end
      endcase
    end

    if (!pump_on)
      next_ph = msi_pkg::PH_SELF_CHECK;
    else if (chain_code == msi_pkg::CHAIN_OK && servo_on && gauge_on && link_on)
      next_ph = msi_pkg::PH_MOTION;
    else
      next_ph = msi_pkg::PH_MACHINE_CHECK;

    if (next_ph != msi_pkg::PH_MOTION) begin
      // dropping out of motion on a chain fault latches faulted
      status_now = (phase_now == msi_pkg::PH_MOTION && chain_code != msi_pkg::CHAIN_OK)
                   ? msi_pkg::ST_FAULTED : msi_pkg::ST_DISABLED;
      mode_now = msi_pkg::MD_MANUAL;
    end else if (status_now != msi_pkg::ST_DISABLED) begin
      case (cond_now)
        msi_pkg::COND_LENGTH, msi_pkg::COND_FORCE:
          status_now = msi_pkg::ST_SAMPLE_LIMIT;
        msi_pkg::COND_STOPPED, msi_pkg::COND_MOVING:
          status_now = msi_pkg::ST_ENABLED;
        default:
          status_now = msi_pkg::ST_MACHINE_LIMIT;
      endcase
    end else begin
      mode_now = msi_pkg::MD_MANUAL;
    end
    phase_now = next_ph;

    r.result_code       = code;
    r.machine_phase     = phase_now;
    r.motion_status_out = status_now;
    r.motion_mode_out   = mode_now;
    return r;
  endfunction

  task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    msi_pkg::result_t want;
    if (rst) begin
      phase_now  = msi_pkg::PH_SELF_CHECK;
      pump_on    = 1'b0;
      chain_code = msi_pkg::CHAIN_OK;
      servo_on   = 1'b0;
      gauge_on   = 1'b0;
      link_on    = 1'b0;
      status_now = msi_pkg::ST_DISABLED;
      cond_now   = msi_pkg::COND_STOPPED;
      mode_now   = msi_pkg::MD_MANUAL;
      interlock_reports.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      // compare before queuing: a result never belongs to a beat of this edge
      if (result_valid && !result_stall) begin
        if (interlock_reports.size() == 0) begin
          $error("result beat with nothing outstanding: code %0d phase %0d status %0d mode %0d",
                 result.result_code, result.machine_phase, result.motion_status_out,
                 result.motion_mode_out);
          fail_count++;
        end else begin
          want = interlock_reports.pop_front();
          check_field("result_code", 3'(want.result_code), 3'(result.result_code));
          check_field("machine_phase", 3'(want.machine_phase), 3'(result.machine_phase));
          check_field("motion_status_out", want.motion_status_out,
                      result.motion_status_out);
          check_field("motion_mode_out", 3'(want.motion_mode_out),
                      3'(result.motion_mode_out));
        end
      end
      if (item_valid && !item_stall)
        interlock_reports.push_back(apply_write(item));
      pending_count = interlock_reports.size();
    end
  end

endmodule

// ===== sim/motion_safety_interlock_test.sv =====
module motion_safety_interlock_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_BEATS = 567;

  logic             clk;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  msi_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  msi_pkg::result_t result;
  int               fail_count;
  int               pending_count;

  int      cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_requests = 0;

  motion_safety_interlock dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  msi_scoreboard watch (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_requests > holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_beat(msi_pkg::item_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    do @(posedge clk); while (item_stall);
  endtask

  // mostly legal writes, links biased up so motion is reached often
  task automatic send_random_beat();
    msi_pkg::item_t beat;
    beat.operation = 3'($urandom_range(7));
    if ($urandom_range(99) < 12) begin
      beat.value = 4'($urandom_range(15));
    end else begin
      case (msi_pkg::op_t'(beat.operation))
        msi_pkg::OP_CHAIN:
          beat.value = ($urandom_range(99) < 70) ? 4'(msi_pkg::CHAIN_OK)
                                                 : 4'($urandom_range(4, 1));
        msi_pkg::OP_STATUS:
          beat.value = 4'($urandom_range(msi_pkg::ST_MACHINE_LIMIT));
        msi_pkg::OP_CONDITION:
          beat.value = 4'($urandom_range(msi_pkg::COND_MOVING));
        msi_pkg::OP_MODE:
          beat.value = 4'($urandom_range(msi_pkg::MD_TEST_RUN));
        default:
          beat.value = ($urandom_range(99) < 85) ? 4'd1 : 4'd0;
      endcase
    end
    send_beat(beat);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  initial begin
    msi_pkg::item_t directed[];
    directed = '{
      '{msi_pkg::OP_MODE,       4'(msi_pkg::MD_TEST_RUN)},       // refused from manual
      '{msi_pkg::OP_PUMP,       4'd1},
      '{msi_pkg::OP_SERVO_OK,   4'd1},
      '{msi_pkg::OP_GAUGE_LINK, 4'd1},
      '{msi_pkg::OP_SERVO_LINK, 4'd1},                           // motion, still disabled
      '{msi_pkg::OP_MODE,       4'(msi_pkg::MD_TEST)},           // forced back to manual
      '{msi_pkg::OP_STATUS,     4'(msi_pkg::ST_ENABLED)},
      '{msi_pkg::OP_MODE,       4'(msi_pkg::MD_TEST)},
      '{msi_pkg::OP_MODE,       4'(msi_pkg::MD_TEST_RUN)},
      '{msi_pkg::OP_CONDITION,  msi_pkg::COND_LENGTH},
      '{msi_pkg::OP_CONDITION,  msi_pkg::COND_TENSION},
      '{msi_pkg::OP_CONDITION,  msi_pkg::COND_MOVING},
      '{msi_pkg::OP_CONDITION,  msi_pkg::COND_DOOR},
      '{msi_pkg::OP_CONDITION,  msi_pkg::COND_STOPPED},
      '{msi_pkg::OP_CHAIN,      4'd4},                           // chain fault out of motion
      '{msi_pkg::OP_CHAIN,      4'(msi_pkg::CHAIN_OK)},
      '{msi_pkg::OP_STATUS,     4'(msi_pkg::ST_MACHINE_LIMIT)},  // write then remapped
      '{msi_pkg::OP_STATUS,     4'(msi_pkg::ST_DISABLED)},
      '{msi_pkg::OP_PUMP,       4'd0},
      '{msi_pkg::OP_CONDITION,  4'd9},
      '{msi_pkg::OP_MODE,       4'd3},
      '{msi_pkg::OP_PUMP,       4'd15},
      '{msi_pkg::OP_CHAIN,      4'd15},
      '{msi_pkg::OP_SERVO_OK,   4'd15},
      '{msi_pkg::OP_GAUGE_LINK, 4'd15},
      '{msi_pkg::OP_SERVO_LINK, 4'd15},
      '{msi_pkg::OP_STATUS,     4'd15},
      '{msi_pkg::OP_CONDITION,  4'd15},
      '{msi_pkg::OP_MODE,       4'd15}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_beat(directed[i]);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 33 : (ph == 1) ? 51 : 0;
      recv_stall_pct = (ph == 0) ? 51 : (ph == 1) ? 33 : 0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ((ph == 0 && n == 200) || (ph == 2 && n == 300))
          hold_requests++;
        send_random_beat();
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== motion_safety_interlock.f =====
design/msi_pkg.sv
design/msi_core.sv
design/motion_safety_interlock.sv
design/msi_checker.sv
sim/msi_checker.sv
sim/motion_safety_interlock_test.sv
